// File: rtl/pse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// shared types, constants and byte helpers for the png stored-stream encoder
// ----------------------------------------------------------------------------
package pse_pkg;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t       cmd;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic [7:0] ch3;
    } item_t;

    localparam logic [1:0]  CFG_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_HEIGHT = 2'd1;
    localparam logic [1:0]  CFG_SWAP   = 2'd2;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
    localparam logic [31:0] IEND_CRC   = 32'hAE426082;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] BLOCK_MAX  = 16'hFFFF;

    localparam int          IDX_W      = 6;
    localparam logic [5:0]  HDR_LAST   = 6'd42;
    localparam logic [5:0]  FIN_LAST   = 6'd19;
    localparam logic [2:0]  POS_LAST   = 3'd4;
    localparam logic [2:0]  BH_LAST    = 3'd4;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            2'd3: r = w[7:0];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // fixed bytes of the file head: signature, ihdr length and type, ihdr tail,
    // idat type and zlib header
    function automatic logic [7:0] hdr_const(input logic [5:0] idx);
        logic [7:0] r;
        r = 8'd0;
        case (idx)
            6'd0:  r = 8'd137;
            6'd1:  r = 8'd80;
            6'd2:  r = 8'd78;
            6'd3:  r = 8'd71;
            6'd4:  r = 8'd13;
            6'd5:  r = 8'd10;
            6'd6:  r = 8'd26;
            6'd7:  r = 8'd10;
            6'd11: r = 8'd13;
            6'd12: r = "I";
            6'd13: r = "H";
            6'd14: r = "D";
            6'd15: r = "R";
            6'd24: r = 8'd8;
            6'd25: r = 8'd6;
            6'd37: r = "I";
            6'd38: r = "D";
            6'd39: r = "A";
            6'd40: r = "T";
            6'd41: r = 8'h78;
            6'd42: r = 8'h01;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] iend_const(input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0: r = "I";
            2'd1: r = "E";
            2'd2: r = "N";
            2'd3: r = "D";
            default: r = "D";
        endcase
        return r;
    endfunction

endpackage

// File: rtl/png_stored_stream_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_top
// rgba pixels in, png file bytes with an uncompressed zlib stream out
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready: command 0 starts a file, 1 carries a pixel
//   output channel out_valid/out_ready: one file byte per word, last_of_item
//   marks the final byte of each input word, file_done the final iend byte
//   config port: cfg_we with cfg_index 0 width, 1 height, 2 swap_red_blue
// byte counts and rate
//   a start gives 43 bytes, a pixel 4 to 10 bytes; the last pixel adds
//   20 tail bytes; the byte sequencer moves one byte per cycle while
//   out_ready is high, passing its idle state between items; an input
//   word goes through the skid register and the queue to the idle state;
//   a pixel with no frame gets its single error byte from that state
// reset
//   all queues empty, no frame active, width and height 1, no swap
// stall
//   the output register holds its byte while out_ready is low; the two-entry
//   queue and input skid stage keep taking words until they fill
// ----------------------------------------------------------------------------
module png_stored_stream_encoder_top
#(
    parameter int MAX_WIDTH  = 8192,
    parameter int MAX_HEIGHT = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  first_channel,
    input  logic [7:0]  second_channel,
    input  logic [7:0]  third_channel,
    input  logic [7:0]  fourth_channel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_item,
    output logic        file_done,
    output logic        error
);
    import pse_pkg::*;

    logic [13:0] width_reg;
    logic [13:0] height_reg;
    logic        swap_reg;
    logic        push;
    item_t       push_item;
    logic        queue_full;
    logic        pop;
    logic        pop_valid;
    item_t       pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 14'd1;
            height_reg <= 14'd1;
            swap_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == CFG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            if (cfg_index == CFG_SWAP)
            begin
                swap_reg <= cfg_data[0];
            end
        end
    end

    pse_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .fourth_channel (fourth_channel),
        .swap_red_blue  (swap_reg),
        .push           (push),
        .push_item      (push_item),
        .queue_full     (queue_full)
    );

    pse_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    pse_back
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pop_valid    (pop_valid),
        .pop_item     (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .file_done    (file_done),
        .error        (error)
    );

endmodule

// File: rtl/pse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_front
// input skid stage: takes words, orders the channels and hands them to the queue
// ----------------------------------------------------------------------------
module pse_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           command,
    input  logic [7:0]     first_channel,
    input  logic [7:0]     second_channel,
    input  logic [7:0]     third_channel,
    input  logic [7:0]     fourth_channel,
    input  logic           swap_red_blue,
    output logic           push,
    output pse_pkg::item_t push_item,
    input  logic           queue_full
);
    import pse_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t hold_item_next;
    logic  take;

    assign push     = hold_valid_reg && !queue_full;
    assign in_ready = !hold_valid_reg || !queue_full;
    assign take     = in_valid && in_ready;
    assign push_item = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (push)
        begin
            hold_valid_next = 1'b0;
        end
        if (take)
        begin
            hold_valid_next    = 1'b1;
            hold_item_next.cmd = command ? CMD_PIXEL : CMD_START;
            hold_item_next.ch1 = second_channel;
            hold_item_next.ch3 = fourth_channel;
            // bgra input
            if (swap_red_blue)
            begin
                hold_item_next.ch0 = third_channel;
                hold_item_next.ch2 = first_channel;
            end
            else
            begin
                hold_item_next.ch0 = first_channel;
                hold_item_next.ch2 = third_channel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

endmodule

// File: rtl/pse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_queue
// two-entry queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
module pse_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pse_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output pse_pkg::item_t pop_item
);
    import pse_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/pse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_back
// byte sequencer: file head, stored blocks, adler-32 and crc-32, file tail
// ----------------------------------------------------------------------------
module pse_back
#(
    parameter int MAX_WIDTH  = 8192,
    parameter int MAX_HEIGHT = 8192
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [13:0]    image_width,
    input  logic [13:0]    image_height,
    input  logic           pop_valid,
    input  pse_pkg::item_t pop_item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           last_of_item,
    output logic           file_done,
    output logic           error
);
    import pse_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RAW_W = WW + HW + 2;
    localparam int DIM_W = (WW > 14) ? WW : 14;
    localparam int DIMH_W = (HW > 14) ? HW : 14;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_HDR  = 4'b0010,
        ST_PIX  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t           state_reg,  state_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic [2:0]       pos_reg,    pos_next;
    logic [2:0]       bh_reg,     bh_next;
    item_t            pix_reg,    pix_next;
    logic [WW-1:0]    fw_reg,     fw_next;
    logic [HW-1:0]    fh_reg,     fh_next;
    logic [WW-1:0]    col_reg,    col_next;
    logic [31:0]      crc_reg,    crc_next;
    logic [15:0]      alo_reg,    alo_next;
    logic [15:0]      ahi_reg,    ahi_next;
    logic [15:0]      blk_reg,    blk_next;
    logic [RAW_W-1:0] left_reg,   left_next;
    logic             active_reg, active_next;
    logic             ov_reg,     ov_next;
    logic [7:0]       ob_reg,     ob_next;
    logic             ol_reg,     ol_next;
    logic             od_reg,     od_next;
    logic             oe_reg,     oe_next;

    logic [RAW_W-1:0] raw_reg;
    logic [23:0]      q1_reg;
    logic [15:0]      lo_reg;
    logic [23:0]      nblk_reg;
    logic [31:0]      zlen_reg;

    logic        step;
    logic        emit;
    logic [7:0]  byte_c;
    logic        last_c;
    logic        done_c;
    logic        err_c;
    logic        crc_use;
    logic        crc_init;
    logic        is_bh;
    logic [39:0] left_ext;
    logic [15:0] len_c;
    logic [WW-1:0] fw_clamp;
    logic [HW-1:0] fh_clamp;
    logic [7:0]  raw_byte;
    logic [16:0] alo_sum;
    logic [15:0] alo_mod;
    logic [16:0] ahi_sum;
    logic [39:0] y_c;
    logic [24:0] s_c;
    logic [16:0] s2_c;

    assign step      = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign last_of_item = ol_reg;
    assign file_done = od_reg;
    assign error     = oe_reg;

    // frame size, zero taken as one, saturated at the maximum
    always_comb
    begin
        if (image_width == 14'd0)
        begin
            fw_clamp = WW'(1);
        end
        else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH))
        begin
            fw_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            fw_clamp = WW'(image_width);
        end
        if (image_height == 14'd0)
        begin
            fh_clamp = HW'(1);
        end
        else if (DIMH_W'(image_height) > DIMH_W'(MAX_HEIGHT))
        begin
            fh_clamp = HW'(MAX_HEIGHT);
        end
        else
        begin
            fh_clamp = HW'(image_height);
        end
    end

    // idat length: raw bytes, stored block count by 65535, zlib framing
    assign y_c  = 40'(raw_reg) + 40'd65534;
    assign s_c  = 25'(q1_reg) + 25'(lo_reg);
    assign s2_c = 17'(s_c[24:16]) + 17'(s_c[15:0]);

    always_ff @(posedge clk)
    begin
        raw_reg  <= RAW_W'(fh_reg) * RAW_W'({fw_reg, 2'b00} + (WW + 2)'(1));
        q1_reg   <= y_c[39:16];
        lo_reg   <= y_c[15:0];
        nblk_reg <= q1_reg + 24'(s_c[24:16]) + 24'(s2_c >= 17'(BLOCK_MAX));
        zlen_reg <= 32'(40'(raw_reg) + 40'(nblk_reg) * 40'd5 + 40'd6);
    end

    assign left_ext = 40'(left_reg);
    assign len_c    = (left_ext > 40'(BLOCK_MAX)) ? BLOCK_MAX : left_reg[15:0];
    assign is_bh    = (blk_reg == 16'd0) || (bh_reg != 3'd0);

    always_comb
    begin
        unique case (pos_reg)
            3'd1:    raw_byte = pix_reg.ch0;
            3'd2:    raw_byte = pix_reg.ch1;
            3'd3:    raw_byte = pix_reg.ch2;
            3'd4:    raw_byte = pix_reg.ch3;
            default: raw_byte = 8'd0;
        endcase
    end

    assign alo_sum = 17'(alo_reg) + 17'(raw_byte);
    assign alo_mod = (alo_sum >= ADLER_MOD) ? 16'(alo_sum - ADLER_MOD) : alo_sum[15:0];
    assign ahi_sum = 17'(ahi_reg) + 17'(alo_mod);

    always_comb
    begin
        pop      = 1'b0;
        emit     = 1'b0;
        byte_c   = 8'd0;
        last_c   = 1'b0;
        done_c   = 1'b0;
        err_c    = 1'b0;
        crc_use  = 1'b0;
        crc_init = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop = pop_valid && step;
                if (pop_valid && pop_item.cmd == CMD_PIXEL && !active_reg)
                begin
                    emit   = 1'b1;
                    err_c  = 1'b1;
                    last_c = 1'b1;
                end
            end
            ST_HDR:
            begin
                emit   = 1'b1;
                last_c = (idx_reg == HDR_LAST);
                priority if (idx_reg < 6'd12)
                begin
                    byte_c = hdr_const(idx_reg);
                end
                else if (idx_reg < 6'd16)
                begin
                    byte_c   = hdr_const(idx_reg);
                    crc_use  = 1'b1;
                    crc_init = (idx_reg == 6'd12);
                end
                else if (idx_reg < 6'd20)
                begin
                    byte_c  = be_byte(32'(fw_reg), 2'(idx_reg - 6'd16));
                    crc_use = 1'b1;
                end
                else if (idx_reg < 6'd24)
                begin
                    byte_c  = be_byte(32'(fh_reg), 2'(idx_reg - 6'd20));
                    crc_use = 1'b1;
                end
                else if (idx_reg < 6'd29)
                begin
                    byte_c  = hdr_const(idx_reg);
                    crc_use = 1'b1;
                end
                else if (idx_reg < 6'd33)
                begin
                    byte_c = be_byte(~crc_reg, 2'(idx_reg - 6'd29));
                end
                else if (idx_reg < 6'd37)
                begin
                    byte_c = be_byte(zlen_reg, 2'(idx_reg - 6'd33));
                end
                else
                begin
                    byte_c   = hdr_const(idx_reg);
                    crc_use  = 1'b1;
                    crc_init = (idx_reg == 6'd37);
                end
            end
            ST_PIX:
            begin
                emit    = 1'b1;
                crc_use = 1'b1;
                if (is_bh)
                begin
                    unique case (bh_reg)
                        3'd0:    byte_c = {7'd0, left_ext <= 40'(BLOCK_MAX)};
                        3'd1:    byte_c = len_c[7:0];
                        3'd2:    byte_c = len_c[15:8];
                        3'd3:    byte_c = ~len_c[7:0];
                        default: byte_c = ~len_c[15:8];
                    endcase
                end
                else
                begin
                    byte_c = raw_byte;
                    last_c = (pos_reg == POS_LAST) && (left_reg != RAW_W'(1));
                end
            end
            ST_FIN:
            begin
                emit   = 1'b1;
                last_c = (idx_reg == FIN_LAST);
                done_c = (idx_reg == FIN_LAST);
                priority if (idx_reg < 6'd4)
                begin
                    byte_c  = be_byte({ahi_reg, alo_reg}, idx_reg[1:0]);
                    crc_use = 1'b1;
                end
                else if (idx_reg < 6'd8)
                begin
                    byte_c = be_byte(~crc_reg, idx_reg[1:0]);
                end
                else if (idx_reg < 6'd12)
                begin
                    byte_c = 8'd0;
                end
                else if (idx_reg < 6'd16)
                begin
                    byte_c = iend_const(idx_reg[1:0]);
                end
                else
                begin
                    byte_c = be_byte(IEND_CRC, idx_reg[1:0]);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        bh_next     = bh_reg;
        pix_next    = pix_reg;
        fw_next     = fw_reg;
        fh_next     = fh_reg;
        col_next    = col_reg;
        crc_next    = crc_reg;
        alo_next    = alo_reg;
        ahi_next    = ahi_reg;
        blk_next    = blk_reg;
        left_next   = left_reg;
        active_next = active_reg;
        ov_next     = ov_reg && !out_ready;
        ob_next     = ob_reg;
        ol_next     = ol_reg;
        od_next     = od_reg;
        oe_next     = oe_reg;
        if (step)
        begin
            if (emit)
            begin
                ov_next = 1'b1;
                ob_next = byte_c;
                ol_next = last_c;
                od_next = done_c;
                oe_next = err_c;
            end
            if (emit && crc_use)
            begin
                crc_next = crc_byte(crc_init ? CRC_ONES : crc_reg, byte_c);
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop && pop_item.cmd == CMD_START)
                    begin
                        state_next  = ST_HDR;
                        idx_next    = '0;
                        fw_next     = fw_clamp;
                        fh_next     = fh_clamp;
                        alo_next    = 16'd1;
                        ahi_next    = 16'd0;
                        col_next    = '0;
                        blk_next    = 16'd0;
                        active_next = 1'b0;
                    end
                    else if (pop && active_reg)
                    begin
                        state_next = ST_PIX;
                        pix_next   = pop_item;
                        pos_next   = (col_reg == '0) ? 3'd0 : 3'd1;
                        bh_next    = 3'd0;
                    end
                end
                ST_HDR:
                begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == HDR_LAST)
                    begin
                        state_next  = ST_IDLE;
                        left_next   = raw_reg;
                        active_next = 1'b1;
                    end
                end
                ST_PIX:
                begin
                    if (is_bh)
                    begin
                        if (bh_reg == BH_LAST)
                        begin
                            bh_next  = 3'd0;
                            blk_next = len_c;
                        end
                        else
                        begin
                            bh_next = bh_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        alo_next  = alo_mod;
                        ahi_next  = (ahi_sum >= ADLER_MOD) ? 16'(ahi_sum - ADLER_MOD)
                                                           : ahi_sum[15:0];
                        blk_next  = blk_reg - 16'd1;
                        if (left_reg != '0)
                        begin
                            left_next = left_reg - RAW_W'(1);
                        end
                        if (pos_reg == POS_LAST)
                        begin
                            col_next = ((col_reg + WW'(1)) >= fw_reg) ? '0
                                                                       : col_reg + WW'(1);
                            if (left_reg == RAW_W'(1))
                            begin
                                state_next = ST_FIN;
                                idx_next   = '0;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                end
                ST_FIN:
                begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == FIN_LAST)
                    begin
                        state_next  = ST_IDLE;
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            pos_reg    <= 3'd0;
            bh_reg     <= 3'd0;
            fw_reg     <= WW'(1);
            fh_reg     <= HW'(1);
            col_reg    <= '0;
            crc_reg    <= CRC_ONES;
            alo_reg    <= 16'd1;
            ahi_reg    <= 16'd0;
            blk_reg    <= 16'd0;
            left_reg   <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            bh_reg     <= bh_next;
            fw_reg     <= fw_next;
            fh_reg     <= fh_next;
            col_reg    <= col_next;
            crc_reg    <= crc_next;
            alo_reg    <= alo_next;
            ahi_reg    <= ahi_next;
            blk_reg    <= blk_next;
            left_reg   <= left_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
        od_reg  <= od_next;
        oe_reg  <= oe_next;
    end

endmodule

// File: rtl/pse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_checker
// port-level checks on the encoder output stream
// ----------------------------------------------------------------------------
module pse_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_item,
    input logic       file_done,
    input logic       error
);

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> out_byte == 8'd0)
        else $error("error word with nonzero byte");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && file_done |-> last_of_item && !error)
        else $error("file_done without last_of_item");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last_of_item)
        else $error("error word not last of item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output word changed while stalled");

endmodule

bind png_stored_stream_encoder_top pse_checker u_pse_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .file_done    (file_done),
    .error        (error)
);

// File: tb/png_stored_stream_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_top_tb
// drives start and pixel words into the png encoder and compares every file
// byte against a behavioral model of signature, ihdr, stored blocks, adler-32,
// crc-32 and iend; random gaps on both channels and a long receiver hold-off
// ----------------------------------------------------------------------------
module png_stored_stream_encoder_top_tb;
    import pse_pkg::*;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } png_byte_t;

    typedef struct packed
    {
        cmd_t       cmd;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       chk;
        logic [7:0] exp_first;
        logic       exp_err;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [13:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [7:0]  first_channel;
    logic [7:0]  second_channel;
    logic [7:0]  third_channel;
    logic [7:0]  fourth_channel;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_of_item;
    logic        file_done;
    logic        error;

    png_stored_stream_encoder_top DUT (.*);

    // model state
    logic [13:0] m_width, m_height;
    logic        m_swap;
    logic [31:0] m_crc;
    logic [15:0] m_alo, m_ahi;
    logic [13:0] m_col, m_row;
    logic [15:0] m_blk_left;
    logic [28:0] m_raw_left;
    logic        m_active;
    logic [13:0] m_fw, m_fh;

    png_byte_t expected_bytes[$];
    png_byte_t item_bytes[$];
    int  errors;
    int  stall_cycles;
    bit  quiet;
    bit  hold_off_req;
    bit  first_check;
    logic [7:0] first_exp_byte;
    logic       first_exp_err;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    task automatic emit(input logic [7:0] b, input logic done, input logic err);
        png_byte_t p;
        p.data = b;
        p.last = 1'b0;
        p.done = done;
        p.err  = err;
        item_bytes = {item_bytes, p};
    endtask

    task automatic emit_crc(input logic [7:0] b);
        m_crc = crc_step(m_crc, b);
        emit(b, 1'b0, 1'b0);
    endtask

    task automatic emit_be32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
        begin
            emit(v[8*i +: 8], 1'b0, 1'b0);
        end
    endtask

    task automatic emit_raw(input logic [7:0] b);
        logic [15:0] len;
        logic [16:0] s;
        if (m_blk_left == 16'd0)
        begin
            len = (m_raw_left > 29'd65535) ? 16'hFFFF : m_raw_left[15:0];
            emit_crc((m_raw_left <= 29'd65535) ? 8'd1 : 8'd0);
            emit_crc(len[7:0]);
            emit_crc(len[15:8]);
            emit_crc(~len[7:0]);
            emit_crc(~len[15:8]);
            m_blk_left = len;
        end
        emit_crc(b);
        s = {1'b0, m_alo} + b;
        if (s >= 17'd65521) s = s - 17'd65521;
        m_alo = s[15:0];
        s = {1'b0, m_ahi} + m_alo;
        if (s >= 17'd65521) s = s - 17'd65521;
        m_ahi = s[15:0];
        if (m_blk_left != 0) m_blk_left--;
        if (m_raw_left != 0) m_raw_left--;
    endtask

    task automatic model_start();
        logic [7:0]  hdr[17];
        logic [31:0] c;
        logic [63:0] raw, blocks, zlen;
        logic [7:0]  sig[8];
        logic [7:0]  idat[4];
        sig  = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
        idat = '{"I", "D", "A", "T"};
        m_fw = (m_width == 0) ? 14'd1 : m_width;
        m_fh = (m_height == 0) ? 14'd1 : m_height;
        if (m_fw > 14'd8192) m_fw = 14'd8192;
        if (m_fh > 14'd8192) m_fh = 14'd8192;
        foreach (sig[i]) emit(sig[i], 1'b0, 1'b0);
        hdr = '{"I", "H", "D", "R", 8'd0, 8'd0, {2'b0, m_fw[13:8]}, m_fw[7:0],
                8'd0, 8'd0, {2'b0, m_fh[13:8]}, m_fh[7:0], 8'd8, 8'd6, 8'd0, 8'd0, 8'd0};
        emit_be32(32'd13);
        c = 32'hFFFFFFFF;
        foreach (hdr[i])
        begin
            c = crc_step(c, hdr[i]);
            emit(hdr[i], 1'b0, 1'b0);
        end
        emit_be32(~c);
        raw = 64'(m_fh) * (64'(m_fw) * 4 + 1);
        blocks = (raw + 65534) / 65535;
        zlen = 2 + blocks * 5 + raw + 4;
        emit_be32(zlen[31:0]);
        m_crc = 32'hFFFFFFFF;
        foreach (idat[i]) emit_crc(idat[i]);
        emit_crc(8'h78);
        emit_crc(8'h01);
        m_alo = 16'd1;
        m_ahi = 16'd0;
        m_col = 0;
        m_row = 0;
        m_blk_left = 0;
        m_raw_left = raw[28:0];
        m_active = 1'b1;
    endtask

    task automatic model_finish();
        logic [31:0] adler, c;
        logic [7:0]  iend[4];
        iend = '{"I", "E", "N", "D"};
        adler = {m_ahi, m_alo};
        for (int i = 3; i >= 0; i--) emit_crc(adler[8*i +: 8]);
        emit_be32(~m_crc);
        emit_be32(32'd0);
        c = 32'hFFFFFFFF;
        foreach (iend[i])
        begin
            c = crc_step(c, iend[i]);
            emit(iend[i], 1'b0, 1'b0);
        end
        c = ~c;
        emit(c[31:24], 1'b0, 1'b0);
        emit(c[23:16], 1'b0, 1'b0);
        emit(c[15:8], 1'b0, 1'b0);
        emit(c[7:0], 1'b1, 1'b0);
        m_active = 1'b0;
    endtask

    task automatic predict_png_bytes(input cmd_t cmd, input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] cc, input logic [7:0] d);
        logic [7:0] t;
        item_bytes.delete();
        if (cmd == CMD_START)
        begin
            model_start();
        end
        else if (!m_active)
        begin
            emit(8'd0, 1'b0, 1'b1);
        end
        else
        begin
            if (m_swap)
            begin
                t = a;
                a = cc;
                cc = t;
            end
            if (m_col == 0) emit_raw(8'd0);
            emit_raw(a);
            emit_raw(b);
            emit_raw(cc);
            emit_raw(d);
            m_col++;
            if (m_col >= m_fw)
            begin
                m_col = 0;
                m_row++;
            end
            if (m_raw_left == 0) model_finish();
        end
        item_bytes[item_bytes.size() - 1].last = 1'b1;
        expected_bytes = {expected_bytes, item_bytes};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_WIDTH:  m_width  = val;
            CFG_HEIGHT: m_height = val;
            CFG_SWAP:   m_swap   = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_word(input cmd_t cmd, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] cc, input logic [7:0] d);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        first_channel  <= a;
        second_channel <= b;
        third_channel  <= cc;
        fourth_channel <= d;
        predict_png_bytes(cmd, a, b, cc, d);
        // in_ready is settled at the falling edge and holds until the next rise
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_frame(input int w, input int h, input bit sw, input int npix);
        write_reg(CFG_WIDTH, 14'(w));
        write_reg(CFG_HEIGHT, 14'(h));
        write_reg(CFG_SWAP, 14'(sw));
        send_word(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i < npix; i++)
        begin
            send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // receiver
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            png_byte_t e;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected word", out_byte, 0);
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (first_check)
                begin
                    if (out_byte != first_exp_byte) report_mismatch("table", out_byte, first_exp_byte);
                    if (error != first_exp_err) report_mismatch("table err", error, first_exp_err);
                    first_check = 1'b0;
                end
                if (out_byte != e.data) report_mismatch("out_byte", out_byte, e.data);
                if (last_of_item != e.last) report_mismatch("last_of_item", last_of_item, e.last);
                if (file_done != e.done) report_mismatch("file_done", file_done, e.done);
                if (error != e.err) report_mismatch("error", error, e.err);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    stim_row_t dir_table[] = '{
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1},
        '{CMD_START, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 8'd137, 1'b0},
        '{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h01, 1'b0},
        '{CMD_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1, 8'h00, 1'b1},
        '{CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{CMD_START, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFE, 8'h7F, 8'h80, 8'h01, 1'b0, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    initial
    begin
        int nframes;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_START;
        first_channel = '0;
        second_channel = '0;
        third_channel = '0;
        fourth_channel = '0;
        errors = 0;
        stall_cycles = 0;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        first_check = 1'b0;
        m_width = 1;
        m_height = 1;
        m_swap = 0;
        m_crc = 32'hFFFFFFFF;
        m_alo = 1;
        m_ahi = 0;
        m_col = 0;
        m_row = 0;
        m_blk_left = 0;
        m_raw_left = 0;
        m_active = 0;
        m_fw = 1;
        m_fh = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes first: 1x1 frame; a pixel before it and one after it are errors
        foreach (dir_table[i])
        begin
            if (i == 4)
            begin
                wait_drained();
                write_reg(CFG_WIDTH, 14'd0);
                write_reg(CFG_HEIGHT, 14'd2);
                write_reg(CFG_SWAP, 14'd1);
            end
            if (i == 6)
            begin
                wait_drained();
                write_reg(CFG_WIDTH, 14'd3);
                write_reg(CFG_HEIGHT, 14'd2);
                write_reg(CFG_SWAP, 14'd0);
            end
            if (first_check)
            begin
                in_valid <= 1'b0;
                while (first_check) @(posedge clk);
            end
            if (dir_table[i].chk)
            begin
                wait_drained();
                first_exp_byte = dir_table[i].exp_first;
                first_exp_err  = dir_table[i].exp_err;
                first_check    = 1'b1;
            end
            send_word(dir_table[i].cmd, dir_table[i].c0, dir_table[i].c1,
                      dir_table[i].c2, dir_table[i].c3);
        end
        wait_drained();

        // oversized register values saturate; start abandons this frame
        send_frame(14'h3FFF, 14'h3FFF, 1'b0, 3);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        write_reg(CFG_WIDTH, 14'd16);
        write_reg(CFG_HEIGHT, 14'd8);
        send_word(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0);
        hold_off_req = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        wait_drained();

        nframes = 0;
        while (nframes < 24)
        begin
            int w, h, np;
            if (nframes >= 20) quiet = 1'b1;
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 3);
            np = w * h;
            if ($urandom_range(0, 7) == 0) np = $urandom_range(0, np);
            send_frame(w, h, $urandom_range(0, 1), np);
            if ($urandom_range(0, 4) == 0)
            begin
                send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            wait_drained();
            nframes++;
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
